>>> hw/rtl/gated_nearest_point_matcher_top_assert.svh
// Assertion macros for the nearest point matcher checker.
`ifndef GATED_NEAREST_POINT_MATCHER_TOP_ASSERT_SVH
`define GATED_NEAREST_POINT_MATCHER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define GNPM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define GNPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/gnpm_pkg.sv
// Shared types and constants of the nearest point matcher.
`default_nettype none

package gnpm_pkg;

    localparam int COORD_W            = 16;
    localparam int DIST_W             = 33;
    localparam int INDEX_W            = 8;
    localparam int MAX_POINTS_DEFAULT = 256;

    // 1.5 m squared, in 1/65536 square metres
    localparam logic [DIST_W-1:0] GATE_RESET    = 33'd147456;
    localparam logic [DIST_W-1:0] DIST_ALL_ONES = {DIST_W{1'b1}};

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic                      mode;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      first_of_set;
    } in_t;

    typedef struct packed {
        logic                      matched;
        logic        [INDEX_W-1:0] match_index;
        logic signed [COORD_W-1:0] match_x;
        logic signed [COORD_W-1:0] match_y;
        logic        [DIST_W-1:0]  nearest_dist_sq;
        logic                      set_empty;
        logic                      set_overflow;
    } out_t;

    // Query point travelling down the chain
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } query_t;

    // Running best match travelling down the chain behind the query
    typedef struct packed {
        logic                      found;
        logic        [DIST_W-1:0]  dist_sq;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } best_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/gnpm_cell.sv
// One cell of the search chain: holds a stored point and folds it into the running best.
`default_nettype none

module gnpm_cell #(
    parameter int IDX = 0,
    parameter int IW  = 8,
    parameter int CW  = 9
) (
    input  wire logic                                 clk,
    input  wire logic                                 wr_en,
    input  wire logic [IW-1:0]                        wr_addr,
    input  wire gnpm_pkg::query_t                     wr_point,
    input  wire logic [CW-1:0]                        count,
    input  wire gnpm_pkg::query_t                     q_in,
    output gnpm_pkg::query_t                          q_out,
    input  wire gnpm_pkg::best_t                      best_in,
    input  wire logic [IW-1:0]                        idx_in,
    output gnpm_pkg::best_t                           best_out,
    output logic [IW-1:0]                             idx_out
);

    gnpm_pkg::query_t    stored_reg;
    gnpm_pkg::query_t    q_reg;
    logic [31:0]         sqx_reg;
    logic [31:0]         sqy_reg;
    gnpm_pkg::best_t     best_reg;
    gnpm_pkg::best_t     best_next;
    logic [IW-1:0]       idx_reg;
    logic [IW-1:0]       idx_next;

    logic signed [16:0]  dx;
    logic signed [16:0]  dy;
    logic signed [33:0]  px;
    logic signed [33:0]  py;
    logic [gnpm_pkg::DIST_W-1:0] cand_dist_sq;
    logic                active;
    logic                take;

    assign dx = {q_in.x[15], q_in.x} - {stored_reg.x[15], stored_reg.x};
    assign dy = {q_in.y[15], q_in.y} - {stored_reg.y[15], stored_reg.y};
    assign px = dx * dx;
    assign py = dy * dy;

    assign active       = CW'(IDX) < count;
    assign cand_dist_sq = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign take         = active && (!best_in.found || (cand_dist_sq < best_in.dist_sq));

    always_comb
    begin
        if (take)
        begin
            best_next.found   = 1'b1;
            best_next.dist_sq = cand_dist_sq;
            best_next.x       = stored_reg.x;
            best_next.y       = stored_reg.y;
            idx_next          = IW'(IDX);
        end
        else
        begin
            best_next = best_in;
            idx_next  = idx_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == IW'(IDX)))
        begin
            stored_reg <= wr_point;
        end
        q_reg    <= q_in;
        sqx_reg  <= px[31:0];
        sqy_reg  <= py[31:0];
        best_reg <= best_next;
        idx_reg  <= idx_next;
    end

    assign q_out    = q_reg;
    assign best_out = best_reg;
    assign idx_out  = idx_reg;

endmodule

`default_nettype wire

>>> hw/rtl/gnpm_chain.sv
// Row of search cells with the query and running best passed from cell to cell.
`default_nettype none

module gnpm_chain #(
    parameter int MAX_POINTS = gnpm_pkg::MAX_POINTS_DEFAULT,
    parameter int IW         = 8,
    parameter int CW         = 9
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [IW-1:0]        wr_addr,
    input  wire gnpm_pkg::query_t     wr_point,
    input  wire logic [CW-1:0]        count,
    input  wire gnpm_pkg::query_t     query,
    output gnpm_pkg::best_t           best,
    output logic [IW-1:0]             best_idx
);

    gnpm_pkg::query_t q_link    [0:MAX_POINTS-1];
    gnpm_pkg::best_t  best_link [0:MAX_POINTS];
    logic [IW-1:0]    idx_link  [0:MAX_POINTS];

    assign q_link[0]            = query;
    assign best_link[0].found   = 1'b0;
    assign best_link[0].dist_sq = gnpm_pkg::DIST_ALL_ONES;
    assign best_link[0].x       = '0;
    assign best_link[0].y       = '0;
    assign idx_link[0]          = '0;

    for (genvar i = 0; i < MAX_POINTS; i++)
    begin : g_cell
        if (i < MAX_POINTS - 1)
        begin : g_mid
            gnpm_cell #(
                .IDX (i),
                .IW  (IW),
                .CW  (CW)
            ) u_cell (
                .clk      (clk),
                .wr_en    (wr_en),
                .wr_addr  (wr_addr),
                .wr_point (wr_point),
                .count    (count),
                .q_in     (q_link[i]),
                .q_out    (q_link[i+1]),
                .best_in  (best_link[i]),
                .idx_in   (idx_link[i]),
                .best_out (best_link[i+1]),
                .idx_out  (idx_link[i+1])
            );
        end
        else
        begin : g_last
            gnpm_cell #(
                .IDX (i),
                .IW  (IW),
                .CW  (CW)
            ) u_cell (
                .clk      (clk),
                .wr_en    (wr_en),
                .wr_addr  (wr_addr),
                .wr_point (wr_point),
                .count    (count),
                .q_in     (q_link[i]),
                .q_out    (),
                .best_in  (best_link[i]),
                .idx_in   (idx_link[i]),
                .best_out (best_link[i+1]),
                .idx_out  (idx_link[i+1])
            );
        end
    end

    assign best     = best_link[MAX_POINTS];
    assign best_idx = idx_link[MAX_POINTS];

endmodule

`default_nettype wire

>>> hw/rtl/gated_nearest_point_matcher_top.sv
// Top level of the gated nearest point matcher.
`default_nettype none

// Stores up to MAX_POINTS observed 2D points and, for each query request,
// finds the nearest stored point by exhaustive search, keeping the lowest
// index on a tie. A load request (mode 0) gives no result; first_of_set
// clears the set before the point is stored, and a load beyond capacity
// is dropped and marked in set_overflow. A query request (mode 1) is sent
// down a row of MAX_POINTS cells, one cell a cycle, each cell holding one
// stored point and comparing its squared distance against the running
// best; once the last cell has settled the result is registered in the
// output register. The scan always runs the whole chain, whatever the
// fill level. No new request is taken during a scan. While a result waits
// in the output register loads are still taken; a further query waits
// until that result has been taken or is being taken. matched is set only
// when the nearest squared distance lies strictly below the gate in
// gate_reg, which the user must have written through the cfg channel while
// the block is idle; the block itself does not enforce this. An empty set
// gives matched 0, index and coordinates 0, distance all ones and
// set_empty 1.
module gated_nearest_point_matcher_top #(
    parameter int MAX_POINTS = gnpm_pkg::MAX_POINTS_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire gnpm_pkg::in_t                in_data,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output gnpm_pkg::out_t                    out_data,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [gnpm_pkg::DIST_W-1:0]  cfg_data
);

    localparam int IW   = $clog2(MAX_POINTS);
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int TW   = $clog2(MAX_POINTS + 2);
    localparam int LAST = MAX_POINTS + 1;

    gnpm_pkg::state_t             state_reg;
    gnpm_pkg::state_t             state_next;
    logic [TW-1:0]                timer_reg;
    logic [TW-1:0]                timer_next;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    logic                         overflow_reg;
    logic                         overflow_next;
    logic [gnpm_pkg::DIST_W-1:0]  gate_reg;
    gnpm_pkg::query_t             query_reg;
    gnpm_pkg::out_t               out_reg;
    gnpm_pkg::out_t               out_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;

    logic                         in_take;
    logic                         load_take;
    logic                         query_take;
    logic                         scan_done;
    logic [CW-1:0]                base;
    logic                         wr_en;
    gnpm_pkg::query_t             wr_point;
    gnpm_pkg::best_t              best;
    logic [IW-1:0]                best_idx;

    assign in_take    = in_valid && in_ready;
    assign load_take  = in_take && (in_data.mode == gnpm_pkg::MODE_LOAD);
    assign query_take = in_take && (in_data.mode == gnpm_pkg::MODE_QUERY);
    assign scan_done  = (state_reg == gnpm_pkg::ST_SCAN) && (timer_reg == TW'(LAST));

    // Restart at entry 0 on the first point of a set, else append
    assign base     = in_data.first_of_set ? '0 : count_reg;
    assign wr_en    = load_take && (base < CW'(MAX_POINTS));
    assign wr_point = '{x: in_data.point_x, y: in_data.point_y};

    gnpm_chain #(
        .MAX_POINTS (MAX_POINTS),
        .IW         (IW),
        .CW         (CW)
    ) u_chain (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (base[IW-1:0]),
        .wr_point (wr_point),
        .count    (count_reg),
        .query    (query_reg),
        .best     (best),
        .best_idx (best_idx)
    );

    // Next state: leave idle on a query, return once the last cell has settled
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gnpm_pkg::ST_IDLE:
            begin
                if (query_take)
                begin
                    state_next = gnpm_pkg::ST_SCAN;
                end
            end
            gnpm_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = gnpm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gnpm_pkg::ST_IDLE;
            end
        endcase
    end

    // Handshake outputs: a query waits for a free output register
    always_comb
    begin
        in_ready  = (state_reg == gnpm_pkg::ST_IDLE)
                    && ((in_data.mode == gnpm_pkg::MODE_LOAD) || !out_valid_reg || out_ready);
        cfg_ready = 1'b1;
    end

    // Scan timer and set bookkeeping
    always_comb
    begin
        timer_next    = timer_reg;
        count_next    = count_reg;
        overflow_next = overflow_reg;
        if (query_take)
        begin
            timer_next = '0;
        end
        else if (state_reg == gnpm_pkg::ST_SCAN)
        begin
            timer_next = timer_reg + TW'(1);
        end
        if (load_take)
        begin
            if (in_data.first_of_set)
            begin
                overflow_next = 1'b0;
            end
            if (base < CW'(MAX_POINTS))
            begin
                count_next = base + CW'(1);
            end
            else
            begin
                overflow_next = 1'b1;
            end
        end
    end

    // Result formatting and output register
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (scan_done)
        begin
            out_valid_next           = 1'b1;
            out_next.matched         = best.found && (best.dist_sq < gate_reg);
            out_next.match_index     = best.found ? gnpm_pkg::INDEX_W'(best_idx) : '0;
            out_next.match_x         = best.found ? best.x : '0;
            out_next.match_y         = best.found ? best.y : '0;
            out_next.nearest_dist_sq = best.found ? best.dist_sq : gnpm_pkg::DIST_ALL_ONES;
            out_next.set_empty       = !best.found;
            out_next.set_overflow    = overflow_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gnpm_pkg::ST_IDLE;
            timer_reg     <= '0;
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            gate_reg      <= gnpm_pkg::GATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            timer_reg     <= timer_next;
            count_reg     <= count_next;
            overflow_reg  <= overflow_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                gate_reg <= cfg_data;
            end
        end
    end

    // Payload registers: hold the query point and the pending result
    always_ff @(posedge clk)
    begin
        if (query_take)
        begin
            query_reg <= wr_point;
        end
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

>>> hw/rtl/gnpm_checker.sv
// Port-level checker for the nearest point matcher, bound to the top level.
`default_nettype none

`include "gated_nearest_point_matcher_top_assert.svh"

module gnpm_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           in_valid,
    input wire logic           in_ready,
    input wire gnpm_pkg::in_t  in_data,
    input wire logic           out_valid,
    input wire logic           out_ready,
    input wire gnpm_pkg::out_t out_data
);

    // An empty set never reports a match and carries the fixed fill values
    `GNPM_ASSERT_NOW(a_empty_result, out_valid && out_data.set_empty, !out_data.matched && (out_data.match_index == '0) && (out_data.nearest_dist_sq == gnpm_pkg::DIST_ALL_ONES), "empty set result malformed")

    // A query occupies the chain: no request is taken in the next cycle
    `GNPM_ASSERT_NEXT(a_query_blocks, in_valid && in_ready && (in_data.mode == gnpm_pkg::MODE_QUERY), !in_ready, "request taken during a scan")

    // A load never produces a result
    `GNPM_ASSERT_NEXT(a_load_silent, in_valid && in_ready && (in_data.mode == gnpm_pkg::MODE_LOAD) && !out_valid, !out_valid, "load produced a result")

    // A pending result holds until taken
    `GNPM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "pending result changed")

endmodule

bind gated_nearest_point_matcher_top gnpm_checker u_checker (.*);

`default_nettype wire

>>> verif/gated_nearest_point_matcher_top_tb.sv
// Self-checking testbench for the gated nearest point matcher top level.
module gated_nearest_point_matcher_top_tb;

    localparam int          MAX_POINTS     = gnpm_pkg::MAX_POINTS_DEFAULT;
    // Settling time after the last result: one full scan plus a margin
    localparam int          SETTLE_CYCLES  = MAX_POINTS + 8;
    localparam int unsigned CYCLE_LIMIT    = 1_000_000;
    // Hold the receiver off once this many results have been taken
    localparam int unsigned PRESSURE_AFTER = 25;
    localparam int unsigned HOLD_CYCLES    = 1500;

    // Mirror of the matcher: stored point set, overflow flag and gate.
    // Load requests update the set; each query request leaves one
    // expected result at the back of the queue.
    class match_tracker;
        localparam int CAPACITY = gnpm_pkg::MAX_POINTS_DEFAULT;

        logic signed [gnpm_pkg::COORD_W-1:0] xs [CAPACITY];
        logic signed [gnpm_pkg::COORD_W-1:0] ys [CAPACITY];
        int                                  count;
        bit                                  dropped;
        logic [gnpm_pkg::DIST_W-1:0]         gate;
        gnpm_pkg::out_t                      expected_matches [$];
        int unsigned                         mismatches;

        function new();
            count      = 0;
            dropped    = 1'b0;
            gate       = gnpm_pkg::GATE_RESET;
            mismatches = 0;
        endfunction

        function void set_gate(logic [gnpm_pkg::DIST_W-1:0] value);
            gate = value;
        endfunction

        function int outstanding();
            return expected_matches.size();
        endfunction

        // Exhaustive nearest search; the lowest index wins a tie.
        function gnpm_pkg::out_t predict_match(logic signed [gnpm_pkg::COORD_W-1:0] qx,
                                               logic signed [gnpm_pkg::COORD_W-1:0] qy);
            gnpm_pkg::out_t m;
            longint         dx;
            longint         dy;
            longint         d;
            longint         best;
            int             best_i;
            m = '0;
            m.set_overflow = dropped;
            if (count == 0)
            begin
                m.nearest_dist_sq = gnpm_pkg::DIST_ALL_ONES;
                m.set_empty       = 1'b1;
                return m;
            end
            best   = 0;
            best_i = 0;
            for (int i = 0; i < count; i++)
            begin
                dx = longint'(qx) - longint'(xs[i]);
                dy = longint'(qy) - longint'(ys[i]);
                d  = dx * dx + dy * dy;
                if (i == 0 || d < best)
                begin
                    best   = d;
                    best_i = i;
                end
            end
            m.matched         = (best < longint'(gate));
            m.match_index     = best_i[gnpm_pkg::INDEX_W-1:0];
            m.match_x         = xs[best_i];
            m.match_y         = ys[best_i];
            m.nearest_dist_sq = best[gnpm_pkg::DIST_W-1:0];
            return m;
        endfunction

        function void note_request(gnpm_pkg::in_t req);
            if (req.mode == gnpm_pkg::MODE_LOAD)
            begin
                if (req.first_of_set)
                begin
                    count   = 0;
                    dropped = 1'b0;
                end
                if (count < CAPACITY)
                begin
                    xs[count] = req.point_x;
                    ys[count] = req.point_y;
                    count++;
                end
                else
                    dropped = 1'b1;
            end
            else
                expected_matches.insert(expected_matches.size(),
                                        predict_match(req.point_x, req.point_y));
        endfunction

        function void compare(string field, logic signed [63:0] want,
                              logic signed [63:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_match(gnpm_pkg::out_t got);
            gnpm_pkg::out_t want;
            if (expected_matches.size() == 0)
            begin
                $error("result with no query outstanding: %p", got);
                mismatches++;
                return;
            end
            want = expected_matches.pop_front();
            compare("matched", 64'(want.matched), 64'(got.matched));
            compare("match_index", 64'(want.match_index), 64'(got.match_index));
            compare("match_x", 64'(want.match_x), 64'(got.match_x));
            compare("match_y", 64'(want.match_y), 64'(got.match_y));
            compare("nearest_dist_sq", 64'(want.nearest_dist_sq),
                    64'(got.nearest_dist_sq));
            compare("set_empty", 64'(want.set_empty), 64'(got.set_empty));
            compare("set_overflow", 64'(want.set_overflow), 64'(got.set_overflow));
        endfunction
    endclass

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        in_valid  = 1'b0;
    logic                        in_ready;
    gnpm_pkg::in_t               in_data   = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    gnpm_pkg::out_t              out_data;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [gnpm_pkg::DIST_W-1:0] cfg_data  = '0;

    int unsigned  cycle_count   = 0;
    int unsigned  requests_sent = 0;
    int unsigned  results_taken = 0;
    int unsigned  burst_left    = 0;
    match_tracker tracker;

    gated_nearest_point_matcher_top #(
        .MAX_POINTS (MAX_POINTS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Abandon the run if it hangs.
    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    function automatic gnpm_pkg::in_t make_req(logic mode, int x, int y, logic first);
        gnpm_pkg::in_t req;
        req.mode         = mode;
        req.point_x      = x[gnpm_pkg::COORD_W-1:0];
        req.point_y      = y[gnpm_pkg::COORD_W-1:0];
        req.first_of_set = first;
        return req;
    endfunction

    // Hold the request until the edge that accepts it, then note it.
    // Called just after a rising edge; returns just after the accepting one.
    task automatic send_request(gnpm_pkg::in_t req);
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.note_request(req);
        requests_sent++;
    endtask

    // Offer requests in bursts. Between bursts drop valid for a random gap,
    // now and then a longer one that can span a whole scan; some bursts run
    // long with no gap at all.
    task automatic offer_request(gnpm_pkg::in_t req);
        int unsigned gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 15) == 0)
                gap = $urandom_range(1, 300);
            else
                gap = $urandom_range(1, 20);
            if ($urandom_range(0, 7) == 0)
                burst_left = $urandom_range(40, 80);
            else
                burst_left = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        send_request(req);
    endtask

    // Drop valid, wait for every outstanding result, then wait out the
    // settling time so that the block is idle.
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_gate(logic [gnpm_pkg::DIST_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        tracker.set_gate(value);
    endtask

    // Directed requests, run under the reset gate of 1.5 m (384 units).
    task automatic run_directed();
        // Empty set straight after reset; the first flag on a query is ignored
        offer_request(make_req(gnpm_pkg::MODE_QUERY, 0, 0, 1'b1));
        offer_request(make_req(gnpm_pkg::MODE_QUERY, -32768, 32767, 1'b0));
        // Coordinate extremes and the largest possible distance
        offer_request(make_req(gnpm_pkg::MODE_LOAD, -32768, -32768, 1'b1));
        offer_request(make_req(gnpm_pkg::MODE_QUERY, 32767, 32767, 1'b0));
        offer_request(make_req(gnpm_pkg::MODE_LOAD, 32767, 32767, 1'b0));
        offer_request(make_req(gnpm_pkg::MODE_QUERY, 0, 0, 1'b0));
        offer_request(make_req(gnpm_pkg::MODE_LOAD, 32767, -32768, 1'b0));
        offer_request(make_req(gnpm_pkg::MODE_QUERY, -32768, 32767, 1'b0));
        // New set; distances on and just inside the gate
        offer_request(make_req(gnpm_pkg::MODE_LOAD, 0, 0, 1'b1));
        offer_request(make_req(gnpm_pkg::MODE_QUERY, 384, 0, 1'b0));
        offer_request(make_req(gnpm_pkg::MODE_QUERY, 383, 0, 1'b0));
        offer_request(make_req(gnpm_pkg::MODE_QUERY, 0, -384, 1'b0));
        // Ties: equal distances and a repeated point keep the lowest index
        offer_request(make_req(gnpm_pkg::MODE_LOAD, 10, 0, 1'b1));
        offer_request(make_req(gnpm_pkg::MODE_LOAD, -10, 0, 1'b0));
        offer_request(make_req(gnpm_pkg::MODE_QUERY, 0, 0, 1'b0));
        offer_request(make_req(gnpm_pkg::MODE_LOAD, 0, 10, 1'b0));
        offer_request(make_req(gnpm_pkg::MODE_LOAD, 10, 0, 1'b0));
        offer_request(make_req(gnpm_pkg::MODE_QUERY, 0, 0, 1'b0));
        offer_request(make_req(gnpm_pkg::MODE_QUERY, 10, 0, 1'b0));
        // A query carrying the first flag must leave the set intact
        offer_request(make_req(gnpm_pkg::MODE_QUERY, -10, 0, 1'b1));
    endtask

    // One well-formed set: a load that starts the set, further loads
    // clustered round a centre or spread over the whole range, then a few
    // queries. A filling set runs past capacity so that loads are dropped.
    task automatic run_point_set(bit fill);
        int cx;
        int cy;
        int spread;
        int x;
        int y;
        int n_loads;
        int n_queries;
        bit wide;
        wide   = ($urandom_range(0, 5) == 0);
        cx     = int'($urandom_range(0, 60000)) - 30000;
        cy     = int'($urandom_range(0, 60000)) - 30000;
        spread = $urandom_range(0, 1) ? 600 : 64;
        x      = cx;
        y      = cy;
        if (fill)
            n_loads = MAX_POINTS + int'($urandom_range(1, 6));
        else
            n_loads = $urandom_range(1, 12);
        for (int i = 0; i < n_loads; i++)
        begin
            // Repeat the previous point now and then to force ties
            if (i == 0 || $urandom_range(0, 7) != 0)
            begin
                if (wide)
                begin
                    x = $urandom();
                    y = $urandom();
                end
                else
                begin
                    x = cx + int'($urandom_range(0, 2 * spread)) - spread;
                    y = cy + int'($urandom_range(0, 2 * spread)) - spread;
                end
            end
            offer_request(make_req(gnpm_pkg::MODE_LOAD, x, y, i == 0));
        end
        n_queries = $urandom_range(1, 4);
        for (int q = 0; q < n_queries; q++)
        begin
            if ($urandom_range(0, 3) == 0)
                offer_request(make_req(gnpm_pkg::MODE_QUERY, x, y,
                                       1'($urandom_range(0, 1))));
            else if (wide)
                offer_request(make_req(gnpm_pkg::MODE_QUERY, $urandom(), $urandom(),
                                       1'($urandom_range(0, 1))));
            else
                offer_request(make_req(gnpm_pkg::MODE_QUERY,
                                       cx + int'($urandom_range(0, 4 * spread)) - 2 * spread,
                                       cy + int'($urandom_range(0, 4 * spread)) - 2 * spread,
                                       1'($urandom_range(0, 1))));
        end
    endtask

    // Mostly well-formed sets; the rest appends to the current set or
    // sends unrelated requests with every field random.
    task automatic random_phase(int unsigned n_items, bit fill_first);
        int unsigned stop_at;
        int unsigned pick;
        int          n_more;
        int          cx;
        int          cy;
        stop_at = requests_sent + n_items;
        if (fill_first)
            run_point_set(1'b1);
        while (requests_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                run_point_set(1'b0);
            else if (pick < 85)
            begin
                cx     = int'($urandom_range(0, 60000)) - 30000;
                cy     = int'($urandom_range(0, 60000)) - 30000;
                n_more = $urandom_range(1, 5);
                for (int i = 0; i < n_more; i++)
                    offer_request(make_req(gnpm_pkg::MODE_LOAD,
                                           cx + int'($urandom_range(0, 800)) - 400,
                                           cy + int'($urandom_range(0, 800)) - 400,
                                           1'b0));
                offer_request(make_req(gnpm_pkg::MODE_QUERY, cx, cy, 1'b0));
            end
            else
                offer_request(make_req(1'($urandom_range(0, 1)), $urandom(), $urandom(),
                                       1'($urandom_range(0, 1))));
        end
    endtask

    // Take results on a stall pattern that cycles through four styles:
    // always ready, coin toss, mostly stalled, fixed duty. Once, hold ready
    // low for a long stretch so that the output register fills and the next
    // query backs up into the input.
    initial
    begin : receiver
        int unsigned hold_left;
        bit          hold_done;
        int unsigned style;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                tracker.check_match(out_data);
                results_taken++;
            end
            if (!hold_done && results_taken >= PRESSURE_AFTER)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                style = (cycle_count / 3000) % 4;
                case (style)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 5) == 0);
                    default: out_ready <= ((cycle_count % 7) < 3);
                endcase
            end
        end
    end

    // Reset, directed requests under the reset gate, then one random phase
    // per gate setting: zero (nothing matches), all ones, a small random
    // value, a random value over the full width, and back to the default.
    initial
    begin : stimulus
        logic [gnpm_pkg::DIST_W-1:0] gate;
        tracker = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        settle();
        write_gate('0);
        random_phase(140, 1'b1);

        settle();
        write_gate(gnpm_pkg::DIST_ALL_ONES);
        random_phase(100, 1'b0);

        settle();
        gate = '0;
        gate[31:0] = $urandom_range(0, 400000);
        write_gate(gate);
        random_phase(100, 1'b0);

        settle();
        gate[31:0] = $urandom();
        gate[32]   = 1'($urandom_range(0, 1));
        write_gate(gate);
        random_phase(100, 1'b0);

        settle();
        write_gate(gnpm_pkg::GATE_RESET);
        random_phase(100, 1'b0);

        settle();
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/gnpm_pkg.sv
hw/rtl/gnpm_cell.sv
hw/rtl/gnpm_chain.sv
hw/rtl/gated_nearest_point_matcher_top.sv
hw/rtl/gnpm_checker.sv
verif/gated_nearest_point_matcher_top_tb.sv
